// ===== design/one_wire_bus_master_assert.svh =====
// ----------------------------------------------------------------------------
// One-wire bus master assertion macros
// Concurrent check macros used at the end of the top level. In synthesis the
// macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define OWM_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define OWM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define OWM_ASSERT_SAME(name, clk, rst, ante, cons, msg)
`define OWM_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master package
// Types, operation codes, phase encoding and slot timing constants shared by
// the step logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

   // Operation codes of an input word.
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_RESET  = 3'd1;
   localparam logic [2:0] OP_WRITE  = 3'd2;
   localparam logic [2:0] OP_READ   = 3'd3;
   localparam logic [2:0] OP_TOUCH  = 3'd4;

   // Kind of the running command.
   localparam logic [1:0] KIND_RESET = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_TOUCH = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RESET_LOW   = 2'd0;
   localparam logic [1:0] CSR_ZERO_LOW    = 2'd1;
   localparam logic [1:0] CSR_ONE_LOW     = 2'd2;
   localparam logic [1:0] CSR_READ_SAMPLE = 2'd3;

   // Configuration reset values.
   localparam logic [9:0] RST_RESET_LOW   = 10'd800;
   localparam logic [6:0] RST_ZERO_LOW    = 7'd60;
   localparam logic [3:0] RST_ONE_LOW     = 4'd8;
   localparam logic [3:0] RST_READ_SAMPLE = 4'd8;

   // Fixed phase lengths in microseconds.
   localparam logic [9:0] T_RST_GAP   = 10'd4;
   localparam logic [9:0] T_RST_PULL  = 10'd8;
   localparam logic [9:0] T_RST_S1    = 10'd70;
   localparam logic [9:0] T_RST_S2    = 10'd1;
   localparam logic [9:0] T_RST_S3    = 10'd239;
   localparam logic [9:0] T_RST_GAP2  = 10'd2;
   localparam logic [9:0] T_RST_PULL2 = 10'd60;
   localparam logic [9:0] T_RST_REC   = 10'd200;
   localparam logic [9:0] T_SL_GAP    = 10'd2;
   localparam logic [9:0] T_PULL_ZERO = 10'd16;
   localparam logic [9:0] T_PULL_ONE  = 10'd68;
   localparam logic [9:0] T_REC_WRITE = 10'd32;
   localparam logic [9:0] T_RD_HOLD   = 10'd16;
   localparam logic [9:0] T_RD_PULL   = 10'd19;
   localparam logic [9:0] T_REC_READ  = 10'd59;

   // Presence: first two samples low, third high.
   localparam logic [2:0] PRESENCE_PATTERN = 3'b100;

   typedef enum logic [15:0] {
      PH_IDLE      = 16'h0001,
      PH_RST_LOW   = 16'h0002,
      PH_RST_GAP   = 16'h0004,
      PH_RST_PULL  = 16'h0008,
      PH_RST_S1    = 16'h0010,
      PH_RST_S2    = 16'h0020,
      PH_RST_S3    = 16'h0040,
      PH_RST_GAP2  = 16'h0080,
      PH_RST_PULL2 = 16'h0100,
      PH_RST_REC   = 16'h0200,
      PH_SL_LOW    = 16'h0400,
      PH_SL_GAP    = 16'h0800,
      PH_SL_PULL   = 16'h1000,
      PH_SL_REC    = 16'h2000,
      PH_RD_WAIT   = 16'h4000,
      PH_RD_HOLD   = 16'h8000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [9:0] phase_timer;
      logic [2:0] bit_index;
      logic [1:0] command_kind;
      logic [7:0] send_shift;
      logic [7:0] receive_shift;
      logic [2:0] presence_samples;
      logic       presence_flag;
   } state_type;

   typedef struct packed {
      logic [9:0] reset_low_us;
      logic [6:0] zero_low_us;
      logic [3:0] one_low_us;
      logic [3:0] read_sample_us;
   } cfg_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] data_byte;
      logic       line_level;
   } item_type;

   typedef struct packed {
      logic       drive_low;
      logic       pullup_on;
      logic       busy_res;
      logic       done_res;
      logic [7:0] result_byte;
      logic       presence;
      logic       rejected;
   } result_type;

endpackage

`default_nettype wire

// ===== design/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master, standard speed
// Path: an accepted request waits in the input register, then moves on to the result
// register once that is free; a waiting result word is held while it is stalled.
// Throughput: one word per cycle unless rsp_stall holds a result word; the step
// logic updates the phase machine state between the input and result registers.
// Reset: synchronous, active high; returns the phase machine to idle and
// loads the timing registers with 800, 60, 8 and 8 microseconds.
// ----------------------------------------------------------------------------
`default_nettype none
`include "one_wire_bus_master_assert.svh"

module one_wire_bus_master
   import owm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // Request channel.
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_op,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_line_level,
   // Result channel.
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_drive_low,
   output logic            rsp_pullup_on,
   output logic            rsp_busy_res,
   output logic            rsp_done_res,
   output logic [7:0]      rsp_result_byte,
   output logic            rsp_presence,
   output logic            rsp_rejected,
   // Configuration write channel.
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [9:0] csr_wdata
);

   logic       in_vld_ff, in_vld_in;
   item_type   item_ff;
   logic       out_vld_ff, out_vld_in;
   result_type result_ff;
   state_type  state_ff, state_in;
   cfg_type    cfg_ff;
   result_type step_result;
   logic       req_take;
   logic       out_free;
   logic       advance;

   // Handshake: the input register moves on whenever the result register is free.
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign in_vld_in = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);
   assign csr_ready = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_take) begin
         item_ff <= '{op: req_op, data_byte: req_data_byte, line_level: req_line_level};
      end
   end

   // Step logic for the word in the input register.
   owm_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .item      (item_ff),
      .nxt_state (state_in),
      .result    (step_result)
   );

   // Phase machine state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, phase_timer: 10'd0, bit_index: 3'd0,
                       command_kind: KIND_RESET, send_shift: 8'd0, receive_shift: 8'd0,
                       presence_samples: 3'd0, presence_flag: 1'b0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Timing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{reset_low_us: RST_RESET_LOW, zero_low_us: RST_ZERO_LOW,
                     one_low_us: RST_ONE_LOW, read_sample_us: RST_READ_SAMPLE};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RESET_LOW:   cfg_ff.reset_low_us   <= csr_wdata;
            CSR_ZERO_LOW:    cfg_ff.zero_low_us    <= csr_wdata[6:0];
            CSR_ONE_LOW:     cfg_ff.one_low_us     <= csr_wdata[3:0];
            CSR_READ_SAMPLE: cfg_ff.read_sample_us <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_drive_low   = result_ff.drive_low;
   assign rsp_pullup_on   = result_ff.pullup_on;
   assign rsp_busy_res    = result_ff.busy_res;
   assign rsp_done_res    = result_ff.done_res;
   assign rsp_result_byte = result_ff.result_byte;
   assign rsp_presence    = result_ff.presence;
   assign rsp_rejected    = result_ff.rejected;

   // A finished command leaves the master idle.
   `OWM_ASSERT_SAME(a_done_idle, clock, reset, rsp_valid && rsp_done_res,
                    !rsp_busy_res, "done while busy")
   // A rejected command only happens while a sequence runs.
   `OWM_ASSERT_SAME(a_reject_busy, clock, reset, rsp_valid && rsp_rejected,
                    rsp_busy_res && !rsp_done_res, "reject while idle")
   // The strong driver and the pull-up are never on together.
   `OWM_ASSERT_SAME(a_drive_excl, clock, reset, rsp_valid,
                    !(rsp_drive_low && rsp_pullup_on), "driver and pull-up both on")
   // The phase machine state only changes when a word passes through the step logic.
   `OWM_ASSERT_NEXT(a_state_hold, clock, reset, !advance, $stable(state_ff),
                    "state changed without a word")

endmodule

`default_nettype wire

// ===== design/owm_step.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master step logic
// Combinational update of the phase machine for one input word: starts a
// command, counts down a tick or ends a phase, and forms the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_step
   import owm_pkg::*;
(
   input  state_type  cur_state,
   input  cfg_type    cfg,
   input  item_type   item,
   output state_type  nxt_state,
   output result_type result
);

   // Low time of the next slot: short for read slots and 1 bits.
   function automatic logic [9:0] slot_low_time(input logic [1:0] kind,
                                                input logic [7:0] send,
                                                input cfg_type    c);
      logic [9:0] t;
      if (kind == KIND_READ || send[0]) begin
         t = {6'd0, c.one_low_us};
      end else begin
         t = {3'd0, c.zero_low_us};
      end
      return t;
   endfunction

   logic       slot_read;
   logic       done;
   logic       rej;
   logic [2:0] samples_full;
   logic [7:0] send_next;
   logic [7:0] start_send;
   logic [1:0] start_kind;

   assign slot_read = (cur_state.command_kind == KIND_READ) ||
                      (cur_state.command_kind == KIND_TOUCH && cur_state.send_shift[0]);
   assign samples_full = cur_state.presence_samples | {item.line_level, 2'b00};
   assign send_next = {1'b0, cur_state.send_shift[7:1]};

   // Command kind and send byte of a new command.
   always_comb begin
      unique case (item.op)
         OP_WRITE: start_kind = KIND_WRITE;
         OP_READ:  start_kind = KIND_READ;
         OP_TOUCH: start_kind = KIND_TOUCH;
         default:  start_kind = KIND_RESET;
      endcase
   end
   assign start_send = (start_kind == KIND_READ) ? 8'd0 : item.data_byte;

   // Phase machine update.
   always_comb begin
      nxt_state = cur_state;
      done = 1'b0;
      rej = 1'b0;
      unique case (item.op)
         OP_TICK: begin
            if (cur_state.phase != PH_IDLE) begin
               if (cur_state.phase_timer > 10'd1) begin
                  nxt_state.phase_timer = cur_state.phase_timer - 10'd1;
               end else begin
                  unique case (cur_state.phase)
                     PH_RST_LOW: begin
                        nxt_state.phase = PH_RST_GAP;
                        nxt_state.phase_timer = T_RST_GAP;
                     end
                     PH_RST_GAP: begin
                        nxt_state.phase = PH_RST_PULL;
                        nxt_state.phase_timer = T_RST_PULL;
                     end
                     PH_RST_PULL: begin
                        nxt_state.phase = PH_RST_S1;
                        nxt_state.phase_timer = T_RST_S1;
                     end
                     PH_RST_S1: begin
                        nxt_state.presence_samples = {2'b00, item.line_level};
                        nxt_state.phase = PH_RST_S2;
                        nxt_state.phase_timer = T_RST_S2;
                     end
                     PH_RST_S2: begin
                        nxt_state.presence_samples[1] = item.line_level;
                        nxt_state.phase = PH_RST_S3;
                        nxt_state.phase_timer = T_RST_S3;
                     end
                     PH_RST_S3: begin
                        nxt_state.presence_samples = samples_full;
                        nxt_state.presence_flag = (samples_full == PRESENCE_PATTERN);
                        nxt_state.phase = PH_RST_GAP2;
                        nxt_state.phase_timer = T_RST_GAP2;
                     end
                     PH_RST_GAP2: begin
                        nxt_state.phase = PH_RST_PULL2;
                        nxt_state.phase_timer = T_RST_PULL2;
                     end
                     PH_RST_PULL2: begin
                        nxt_state.phase = PH_RST_REC;
                        nxt_state.phase_timer = T_RST_REC;
                     end
                     PH_RST_REC: begin
                        nxt_state.phase = PH_IDLE;
                        nxt_state.phase_timer = 10'd0;
                        done = 1'b1;
                     end
                     PH_SL_LOW: begin
                        if (slot_read) begin
                           nxt_state.phase = PH_RD_WAIT;
                           nxt_state.phase_timer = {6'd0, cfg.read_sample_us};
                        end else begin
                           nxt_state.receive_shift = {1'b0, cur_state.receive_shift[7:1]};
                           nxt_state.phase = PH_SL_GAP;
                           nxt_state.phase_timer = T_SL_GAP;
                        end
                     end
                     PH_SL_GAP: begin
                        nxt_state.phase = PH_SL_PULL;
                        nxt_state.phase_timer = cur_state.send_shift[0] ? T_PULL_ONE
                                                                        : T_PULL_ZERO;
                     end
                     PH_RD_WAIT: begin
                        nxt_state.receive_shift = {item.line_level,
                                                   cur_state.receive_shift[7:1]};
                        nxt_state.phase = PH_RD_HOLD;
                        nxt_state.phase_timer = T_RD_HOLD;
                     end
                     PH_RD_HOLD: begin
                        nxt_state.phase = PH_SL_PULL;
                        nxt_state.phase_timer = T_RD_PULL;
                     end
                     PH_SL_PULL: begin
                        nxt_state.phase = PH_SL_REC;
                        nxt_state.phase_timer = slot_read ? T_REC_READ : T_REC_WRITE;
                     end
                     PH_SL_REC: begin
                        nxt_state.send_shift = send_next;
                        if (cur_state.bit_index == 3'd7) begin
                           nxt_state.phase = PH_IDLE;
                           nxt_state.phase_timer = 10'd0;
                           done = 1'b1;
                        end else begin
                           nxt_state.bit_index = cur_state.bit_index + 3'd1;
                           nxt_state.phase = PH_SL_LOW;
                           nxt_state.phase_timer = slot_low_time(cur_state.command_kind,
                                                                 send_next, cfg);
                        end
                     end
                     default: begin
                        nxt_state.phase = PH_IDLE;
                        nxt_state.phase_timer = 10'd0;
                     end
                  endcase
               end
            end
         end
         OP_RESET, OP_WRITE, OP_READ, OP_TOUCH: begin
            if (cur_state.phase != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               nxt_state.command_kind = start_kind;
               nxt_state.bit_index = 3'd0;
               nxt_state.receive_shift = 8'd0;
               if (start_kind == KIND_RESET) begin
                  nxt_state.send_shift = 8'd0;
                  nxt_state.presence_samples = 3'd0;
                  nxt_state.phase = PH_RST_LOW;
                  nxt_state.phase_timer = cfg.reset_low_us;
               end else begin
                  nxt_state.send_shift = start_send;
                  nxt_state.phase = PH_SL_LOW;
                  nxt_state.phase_timer = slot_low_time(start_kind, start_send, cfg);
               end
            end
         end
         default: begin
            // Unknown operation codes leave everything as it is.
         end
      endcase
   end

   // Result word shows the state after this input word.
   always_comb begin
      result.drive_low = (nxt_state.phase == PH_RST_LOW) || (nxt_state.phase == PH_SL_LOW);
      result.pullup_on = (nxt_state.phase == PH_RST_PULL) ||
                         (nxt_state.phase == PH_RST_PULL2) ||
                         (nxt_state.phase == PH_SL_PULL);
      result.busy_res = (nxt_state.phase != PH_IDLE);
      result.done_res = done;
      result.result_byte = (done && (nxt_state.command_kind == KIND_READ ||
                                     nxt_state.command_kind == KIND_TOUCH))
                           ? nxt_state.receive_shift : 8'd0;
      result.presence = nxt_state.presence_flag;
      result.rejected = rej;
   end

endmodule

`default_nettype wire

// ===== dv/one_wire_bus_master_test.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master testbench
// Drives command and tick words into the bus master and checks every status
// word against a cycle-free model of the slot sequencer kept in this module;
// typed rows of the short directed table, which runs first with the reset
// timing, are checked against the table. Random phases follow, each with its
// own timing registers: all ones, all zeros, the largest values, and random
// values. Both channels idle and stall at random, except in one steady phase.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_test
   import owm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Operation codes that the block does not decode.
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   localparam int RANDOM_WORDS = 560;
   localparam int PHASE_WORDS  = 100;
   localparam int QUIET_LIMIT  = 4000;
   localparam int PLAN_ROWS    = 14;

   // Status words that can be read straight off the slot timing.
   localparam result_type ST_QUIET     = '0;
   localparam result_type ST_RESET_LOW = '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
   localparam result_type ST_REFUSED   = '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1};
   localparam result_type ST_DONE_PRES = '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0};
   localparam result_type ST_IDLE_PRES = '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0};

   typedef struct packed {
      item_type    w;
      int          reps;
      logic        typed;
      result_type  want;
   } plan_row;

   // Directed words at the reset timing: a reset with presence lasts 1384 us
   // and samples at 882, 883 and 1122 us.
   localparam plan_row PLAN [PLAN_ROWS] = '{
      '{'{OP_TICK,      8'h00, 1'b1},   1, 1'b1, ST_QUIET},
      '{'{OP_SPARE_LO,  8'h00, 1'b0},   1, 1'b1, ST_QUIET},
      '{'{OP_SPARE_MID, 8'hFF, 1'b1},   1, 1'b1, ST_QUIET},
      '{'{OP_SPARE_HI,  8'h00, 1'b0},   1, 1'b1, ST_QUIET},
      '{'{OP_RESET,     8'h00, 1'b1},   1, 1'b1, ST_RESET_LOW},
      '{'{OP_WRITE,     8'hFF, 1'b0},   1, 1'b1, ST_REFUSED},
      '{'{OP_READ,      8'h00, 1'b1},   1, 1'b1, ST_REFUSED},
      '{'{OP_TOUCH,     8'hFF, 1'b1},   1, 1'b1, ST_REFUSED},
      '{'{OP_RESET,     8'h00, 1'b0},   1, 1'b1, ST_REFUSED},
      '{'{OP_TICK,      8'h00, 1'b1}, 881, 1'b0, ST_QUIET},
      '{'{OP_TICK,      8'h00, 1'b0},   2, 1'b0, ST_QUIET},
      '{'{OP_TICK,      8'h00, 1'b1}, 500, 1'b0, ST_QUIET},
      '{'{OP_TICK,      8'h00, 1'b1},   1, 1'b1, ST_DONE_PRES},
      '{'{OP_TICK,      8'h00, 1'b0},   1, 1'b1, ST_IDLE_PRES}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_op = OP_TICK;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_line_level = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_drive_low;
   logic       rsp_pullup_on;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_result_byte;
   logic       rsp_presence;
   logic       rsp_rejected;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_RESET_LOW;
   logic [9:0] csr_wdata = '0;

   // Traffic control and bookkeeping.
   bit         steady = 1'b0;
   int         mistakes = 0;
   int         random_words = 0;
   int         quiet_cycles = 0;
   result_type awaited_status [$];

   // Model of the sequencer: timing registers and phase machine state.
   cfg_type    timing = '{RST_RESET_LOW, RST_ZERO_LOW, RST_ONE_LOW, RST_READ_SAMPLE};
   phase_type  cur_phase = PH_IDLE;
   logic [9:0] timer_us = '0;
   logic [2:0] slot_bit = '0;
   logic [1:0] cmd_kind = KIND_RESET;
   logic [7:0] tx_bits = '0;
   logic [7:0] rx_bits = '0;
   logic [2:0] pres_bits = '0;
   logic       pres_seen = 1'b0;

   always #6 clock = ~clock;

   one_wire_bus_master i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_data_byte  (req_data_byte),
      .req_line_level (req_line_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drive_low  (rsp_drive_low),
      .rsp_pullup_on  (rsp_pullup_on),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_result_byte(rsp_result_byte),
      .rsp_presence   (rsp_presence),
      .rsp_rejected   (rsp_rejected),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   function automatic void enter(phase_type ph, logic [9:0] t);
      cur_phase = ph;
      timer_us = t;
   endfunction

   // A slot reads for a read command, and for a touch whose next bit is 1.
   function automatic bit slot_reads();
      return cmd_kind == KIND_READ || (cmd_kind == KIND_TOUCH && tx_bits[0]);
   endfunction

   function automatic void begin_slot();
      if (slot_reads() || tx_bits[0]) begin
         enter(PH_SL_LOW, 10'(timing.one_low_us));
      end else begin
         enter(PH_SL_LOW, 10'(timing.zero_low_us));
      end
   endfunction

   // Moves on from a phase whose time is up; returns 1 when the command ends.
   function automatic bit close_phase(logic lvl);
      bit fin = 1'b0;
      case (cur_phase)
         PH_RST_LOW:   enter(PH_RST_GAP, T_RST_GAP);
         PH_RST_GAP:   enter(PH_RST_PULL, T_RST_PULL);
         PH_RST_PULL:  enter(PH_RST_S1, T_RST_S1);
         PH_RST_S1: begin
            pres_bits = {2'b00, lvl};
            enter(PH_RST_S2, T_RST_S2);
         end
         PH_RST_S2: begin
            pres_bits[1] = lvl;
            enter(PH_RST_S3, T_RST_S3);
         end
         PH_RST_S3: begin
            pres_bits[2] = lvl;
            pres_seen = (pres_bits == PRESENCE_PATTERN);
            enter(PH_RST_GAP2, T_RST_GAP2);
         end
         PH_RST_GAP2:  enter(PH_RST_PULL2, T_RST_PULL2);
         PH_RST_PULL2: enter(PH_RST_REC, T_RST_REC);
         PH_RST_REC: begin
            enter(PH_IDLE, '0);
            fin = 1'b1;
         end
         PH_SL_LOW: begin
            if (slot_reads()) begin
               enter(PH_RD_WAIT, 10'(timing.read_sample_us));
            end else begin
               // A write slot shifts a zero into the received byte.
               rx_bits = rx_bits >> 1;
               enter(PH_SL_GAP, T_SL_GAP);
            end
         end
         PH_SL_GAP:    enter(PH_SL_PULL, tx_bits[0] ? T_PULL_ONE : T_PULL_ZERO);
         PH_RD_WAIT: begin
            rx_bits = {lvl, rx_bits[7:1]};
            enter(PH_RD_HOLD, T_RD_HOLD);
         end
         PH_RD_HOLD:   enter(PH_SL_PULL, T_RD_PULL);
         PH_SL_PULL:   enter(PH_SL_REC, slot_reads() ? T_REC_READ : T_REC_WRITE);
         PH_SL_REC: begin
            tx_bits = tx_bits >> 1;
            if (slot_bit == 3'd7) begin
               enter(PH_IDLE, '0);
               fin = 1'b1;
            end else begin
               slot_bit = slot_bit + 3'd1;
               begin_slot();
            end
         end
         default:      enter(PH_IDLE, '0);
      endcase
      return fin;
   endfunction

   // Status word that the block reports after taking one input word.
   function automatic result_type bus_status_after(item_type w);
      bit fin = 1'b0;
      bit refused = 1'b0;
      result_type r;
      if (w.op == OP_TICK) begin
         if (cur_phase != PH_IDLE) begin
            if (timer_us <= 10'd1) begin
               fin = close_phase(w.line_level);
            end else begin
               timer_us = timer_us - 10'd1;
            end
         end
      end else if (w.op <= OP_TOUCH) begin
         if (cur_phase != PH_IDLE) begin
            refused = 1'b1;
         end else begin
            case (w.op)
               OP_RESET: cmd_kind = KIND_RESET;
               OP_WRITE: cmd_kind = KIND_WRITE;
               OP_READ:  cmd_kind = KIND_READ;
               default:  cmd_kind = KIND_TOUCH;
            endcase
            slot_bit = '0;
            rx_bits = '0;
            if (cmd_kind == KIND_RESET) begin
               tx_bits = '0;
               pres_bits = '0;
               enter(PH_RST_LOW, timing.reset_low_us);
            end else begin
               tx_bits = (cmd_kind == KIND_READ) ? 8'h00 : w.data_byte;
               begin_slot();
            end
         end
      end
      r.drive_low = (cur_phase == PH_RST_LOW || cur_phase == PH_SL_LOW);
      r.pullup_on = (cur_phase == PH_RST_PULL || cur_phase == PH_RST_PULL2 ||
                     cur_phase == PH_SL_PULL);
      r.busy_res = (cur_phase != PH_IDLE);
      r.done_res = fin;
      r.result_byte = (fin && (cmd_kind == KIND_READ || cmd_kind == KIND_TOUCH)) ?
                      rx_bits : 8'h00;
      r.presence = pres_seen;
      r.rejected = refused;
      return r;
   endfunction

   // Line level for the next tick; around the presence samples it leans
   // toward a responding device so that presence is found now and then.
   function automatic logic pick_level();
      case (cur_phase)
         PH_RST_S1, PH_RST_S2: return ($urandom_range(0, 99) < 30);
         PH_RST_S3:            return ($urandom_range(0, 99) < 70);
         default:              return 1'($urandom_range(0, 1));
      endcase
   endfunction

   function automatic logic [2:0] pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return OP_RESET;
      if (r < 45) return OP_WRITE;
      if (r < 70) return OP_READ;
      return OP_TOUCH;
   endfunction

   // Offers one word, waits for it to be taken, and records its status.
   task automatic send_word(item_type w, logic typed, result_type want);
      result_type got;
      while (!steady && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= w.op;
      req_data_byte <= w.data_byte;
      req_line_level <= w.line_level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = bus_status_after(w);
      awaited_status.push_back(typed ? want : got);
   endtask

   // Stops offering words and waits until every status word is back.
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [9:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_RESET_LOW:   timing.reset_low_us = value;
         CSR_ZERO_LOW:    timing.zero_low_us = value[6:0];
         CSR_ONE_LOW:     timing.one_low_us = value[3:0];
         default:         timing.read_sample_us = value[3:0];
      endcase
   endtask

   task automatic set_timing(logic [9:0] rst_low, logic [9:0] zero_low,
                             logic [9:0] one_low, logic [9:0] sample);
      write_reg(CSR_RESET_LOW, rst_low);
      write_reg(CSR_ZERO_LOW, zero_low);
      write_reg(CSR_ONE_LOW, one_low);
      write_reg(CSR_READ_SAMPLE, sample);
      csr_valid <= 1'b0;
   endtask

   // Mostly complete commands with random content, some refused commands
   // and undecoded words, then ticks until the last command has finished.
   task automatic run_phase(int budget);
      item_type w;
      int used;
      int r;
      used = 0;
      while (used < budget || cur_phase != PH_IDLE) begin
         r = $urandom_range(0, 99);
         w.data_byte = 8'($urandom_range(0, 255));
         w.line_level = pick_level();
         w.op = OP_TICK;
         if (used >= budget) begin
            used++;
         end else if (cur_phase == PH_IDLE) begin
            if (r < 8) begin
               w.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end else if (r >= 15) begin
               w.op = pick_command();
               used++;
            end
         end else if (r < 3) begin
            w.op = pick_command();
            used++;
         end else if (r < 5) begin
            w.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         end else begin
            used++;
         end
         send_word(w, 1'b0, ST_QUIET);
      end
      random_words += used;
   endtask

   // The result side stalls at random except during the steady phase.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 32);
   end

   // Compares each status word taken from the block with the oldest one due.
   always @(posedge clock) begin : check_status
      result_type seen;
      result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_drive_low, rsp_pullup_on, rsp_busy_res, rsp_done_res,
                  rsp_result_byte, rsp_presence, rsp_rejected};
         if (awaited_status.size() == 0) begin
            mistakes++;
            if (mistakes <= 10)
               $display("status word with none due: %p", seen);
         end else begin
            due = awaited_status.pop_front();
            if (seen.drive_low !== due.drive_low || seen.pullup_on !== due.pullup_on ||
                seen.busy_res !== due.busy_res || seen.done_res !== due.done_res ||
                seen.result_byte !== due.result_byte ||
                seen.presence !== due.presence || seen.rejected !== due.rejected) begin
               mistakes++;
               if (mistakes <= 10)
                  $display("status word mismatch: expected %p, got %p", due, seen);
            end
         end
      end
   end

   // Ends the run when no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL one_wire_bus_master");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i;
      int k;
      int p;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset timing.
      for (i = 0; i < PLAN_ROWS; i++) begin
         for (k = 0; k < PLAN[i].reps; k++)
            send_word(PLAN[i].w, PLAN[i].typed, PLAN[i].want);
      end

      // Random phases: shortest, zero, longest, then random timing.
      p = 0;
      while (random_words < RANDOM_WORDS) begin
         settle();
         case (p)
            0: set_timing(10'd1, 10'd1, 10'd1, 10'd1);
            1: set_timing(10'd0, 10'd0, 10'd0, 10'd0);
            2: set_timing(10'd1023, 10'd127, 10'd15, 10'd15);
            default: begin
               set_timing(($urandom_range(0, 9) == 0) ? 10'($urandom_range(1, 1023)) :
                                                         10'($urandom_range(1, 40)),
                          10'($urandom_range(1, 127)), 10'($urandom_range(1, 15)),
                          10'($urandom_range(1, 15)));
            end
         endcase
         steady <= (p == 0);
         run_phase(PHASE_WORDS);
         p++;
      end
      settle();

      if (mistakes == 0) begin
         $display("PASS one_wire_bus_master");
      end else begin
         $display("FAIL one_wire_bus_master");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/owm_pkg.sv
design/owm_step.sv
design/one_wire_bus_master.sv
dv/one_wire_bus_master_test.sv
